// ===== hw/rtl/wfba_pkg.sv =====
// Shared types, codes and the control-store program of the worst-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none
package wfba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 8;

  // Configuration register map (byte addresses; the register index is paddr[2]).
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_BLOCKS_IN_USE = 1'b0;
  localparam logic [3:0]  BLOCKS_IN_USE_RST = 4'd8;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_LOADED    = 2'd0,
    ST_ALLOCATED = 2'd1,
    ST_NO_FIT    = 2'd2
  } status_e;

  // Datapath actions selected by the control word.
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_CAPTURE = 3'd1,
    ACT_SCAN    = 3'd2,
    ACT_ALLOC   = 3'd3,
    ACT_LOAD    = 3'd4
  } uact_e;

  // Branch conditions tested by the sequencer.
  typedef enum logic [1:0] {
    COND_NO_START  = 2'd0,
    COND_IS_LOAD   = 2'd1,
    COND_SCAN_MORE = 2'd2,
    COND_OUT_BUSY  = 2'd3
  } ucond_e;

  localparam int unsigned STEP_W = 3;

  localparam logic [STEP_W-1:0] STEP_WAIT     = 3'd0;
  localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SCAN     = 3'd2;
  localparam logic [STEP_W-1:0] STEP_ALLOC    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_LOAD     = 3'd4;

  typedef struct packed {
    uact_e               act;
    ucond_e              cond;
    logic [STEP_W-1:0]   tgt_true;
    logic [STEP_W-1:0]   tgt_false;
  } uword_t;

  // Condition flags reported by the datapath to the sequencer.
  typedef struct packed {
    logic start;
    logic is_load;
    logic scan_more;
    logic out_busy;
  } dp_flags_t;

  // The program: wait for a transaction, start the scan, loop over the
  // table, then write back and emit (or store a loaded entry and emit).
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      STEP_WAIT:     w = '{ACT_CAPTURE, COND_NO_START,  STEP_WAIT,  STEP_DISPATCH};
      STEP_DISPATCH: w = '{ACT_SCAN,    COND_IS_LOAD,   STEP_LOAD,  STEP_SCAN};
      STEP_SCAN:     w = '{ACT_SCAN,    COND_SCAN_MORE, STEP_SCAN,  STEP_ALLOC};
      STEP_ALLOC:    w = '{ACT_ALLOC,   COND_OUT_BUSY,  STEP_ALLOC, STEP_WAIT};
      STEP_LOAD:     w = '{ACT_LOAD,    COND_OUT_BUSY,  STEP_LOAD,  STEP_WAIT};
      default:       w = '{ACT_NONE,    COND_NO_START,  STEP_WAIT,  STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wfba_seq.sv =====
// Microcode sequencer: step counter, control-store lookup and conditional branching.
`timescale 1ns / 1ps
`default_nettype none
module wfba_seq
  import wfba_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire dp_flags_t flags_i,
  output uact_e          act_o
);

  logic [STEP_W-1:0] step_q, step_d;
  uword_t            uw;
  logic              cond_hit;

  always_comb begin
    uw = ucode_rom(step_q);
    unique case (uw.cond)
      COND_NO_START:  cond_hit = !flags_i.start;
      COND_IS_LOAD:   cond_hit = flags_i.is_load;
      COND_SCAN_MORE: cond_hit = flags_i.scan_more;
      COND_OUT_BUSY:  cond_hit = flags_i.out_busy;
      default:        cond_hit = 1'b0;
    endcase
    step_d = cond_hit ? uw.tgt_true : uw.tgt_false;
    act_o  = uw.act;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wfba_dp.sv =====
// Datapath: block tables, scan registers, worst-fit compare, write-back and result register.
`timescale 1ns / 1ps
`default_nettype none
module wfba_dp
  import wfba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire uact_e       act_i,
  input  wire logic [3:0]  blocks_in_use_i,
  input  wire logic        in_valid_i,
  input  wire logic        operation_i,
  input  wire logic [2:0]  block_index_i,
  input  wire logic [7:0]  block_label_i,
  input  wire logic [15:0] block_space_i,
  input  wire logic [15:0] request_size_i,
  input  wire logic [7:0]  request_tag_i,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output logic [1:0]       status_o,
  output logic [7:0]       granted_label_o,
  output logic [2:0]       granted_index_o,
  output logic [15:0]      space_left_o,
  output logic [7:0]       echo_tag_o,
  output dp_flags_t        flags_o
);

  localparam int unsigned CNT_BITS = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW       = (CNT_BITS > 4) ? CNT_BITS : 4;
  localparam int unsigned AW       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_BLOCKS);

  // Tables; an entry whose valid bit is clear reads as zero.
  logic [15:0]           space_mem [MAX_BLOCKS];
  logic [7:0]            label_mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] vld_q;

  // Captured transaction.
  op_e         op_q;
  logic [2:0]  slot_q;
  logic [7:0]  label_q;
  logic [15:0] space_q;
  logic [15:0] req_q;
  logic [7:0]  tag_q;

  // Scan state.
  logic [CW-1:0] idx_q, idx_d;
  logic          rd_pend_q, rd_pend_d;
  logic          found_q, found_d;
  logic [15:0]   best_space_q;
  logic [7:0]    best_label_q;
  logic [CW-1:0] best_idx_q;
  logic [15:0]   rd_space_q;
  logic [7:0]    rd_label_q;
  logic          rd_vld_q;
  logic [CW-1:0] rd_idx_q;

  // Result register.
  logic        out_valid_q, out_valid_d;
  status_e     status_q;
  logic [7:0]  glabel_q;
  logic [2:0]  gindex_q;
  logic [15:0] sleft_q;
  logic [7:0]  etag_q;

  logic [CW-1:0] cnt_lim, biu_ext, slot_ext;
  logic          capture, issue, take, out_busy, emit, load_ok;
  logic          wr_en, lbl_we, vld_set;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_space, cand_space, alloc_left;
  logic [7:0]    cand_label;

  always_comb begin
    biu_ext    = CW'(blocks_in_use_i);
    cnt_lim    = (biu_ext > MAX_C) ? MAX_C : biu_ext;
    slot_ext   = CW'(slot_q);
    load_ok    = slot_ext < MAX_C;

    capture    = (act_i == ACT_CAPTURE) && in_valid_i;
    issue      = (act_i == ACT_SCAN) && (idx_q < cnt_lim);
    rd_addr    = idx_q[AW-1:0];

    cand_space = rd_vld_q ? rd_space_q : '0;
    cand_label = rd_vld_q ? rd_label_q : '0;
    // Strictly larger replaces the current best, so ties keep the lowest index.
    take       = (act_i == ACT_SCAN) && rd_pend_q && (cand_space >= req_q) &&
                 (!found_q || (cand_space > best_space_q));

    out_busy   = out_valid_q && out_stall_i;
    emit       = ((act_i == ACT_ALLOC) || (act_i == ACT_LOAD)) && !out_busy;
    alloc_left = best_space_q - req_q;

    wr_en    = 1'b0;
    lbl_we   = 1'b0;
    vld_set  = 1'b0;
    wr_addr  = best_idx_q[AW-1:0];
    wr_space = alloc_left;
    if (emit && (act_i == ACT_LOAD) && load_ok) begin
      wr_en    = 1'b1;
      lbl_we   = 1'b1;
      vld_set  = 1'b1;
      wr_addr  = slot_ext[AW-1:0];
      wr_space = space_q;
    end else if (emit && (act_i == ACT_ALLOC) && found_q) begin
      wr_en = 1'b1;
    end

    idx_d     = idx_q;
    rd_pend_d = rd_pend_q;
    found_d   = found_q || take;
    if (capture) begin
      idx_d     = '0;
      rd_pend_d = 1'b0;
      found_d   = 1'b0;
    end else if (act_i == ACT_SCAN) begin
      rd_pend_d = issue;
      if (issue) begin
        idx_d = idx_q + 1'b1;
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (vld_set) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      space_mem[wr_addr] <= wr_space;
    end
    if (lbl_we) begin
      label_mem[wr_addr] <= label_q;
    end
    if (issue) begin
      rd_space_q <= space_mem[rd_addr];
      rd_label_q <= label_mem[rd_addr];
      rd_vld_q   <= vld_q[rd_addr];
      rd_idx_q   <= idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      op_q    <= op_e'(operation_i);
      slot_q  <= block_index_i;
      label_q <= block_label_i;
      space_q <= block_space_i;
      req_q   <= request_size_i;
      tag_q   <= request_tag_i;
    end
    if (take) begin
      best_space_q <= cand_space;
      best_label_q <= cand_label;
      best_idx_q   <= rd_idx_q;
    end
    if (emit) begin
      etag_q <= tag_q;
      if (act_i == ACT_LOAD) begin
        status_q <= ST_LOADED;
        glabel_q <= '0;
        gindex_q <= '0;
        sleft_q  <= '0;
      end else if (found_q) begin
        status_q <= ST_ALLOCATED;
        glabel_q <= best_label_q;
        gindex_q <= best_idx_q[2:0];
        sleft_q  <= alloc_left;
      end else begin
        status_q <= ST_NO_FIT;
        glabel_q <= '0;
        gindex_q <= '0;
        sleft_q  <= '0;
      end
    end
  end

  assign flags_o.start     = in_valid_i;
  assign flags_o.is_load   = (op_q == OP_LOAD);
  assign flags_o.scan_more = issue || rd_pend_q;
  assign flags_o.out_busy  = out_busy;

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_label_o = glabel_q;
  assign granted_index_o = gindex_q;
  assign space_left_o    = sleft_q;
  assign echo_tag_o      = etag_q;

endmodule
`default_nettype wire

// ===== hw/rtl/worst_fit_block_allocator.sv =====
// Worst-fit block allocator: top level with configuration port, sequencer and datapath.
//
// Input channel (in_valid_i / in_stall_o) carries one transaction per request:
// operation 0 stores a label and free space into a table slot, operation 1
// asks for request_size_i and is granted the scanned block with the most free
// space (lowest slot on ties), which is then reduced by the request.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// transaction, carrying request_tag_i back as echo_tag_o.
// A load passes through the dispatch and load steps to the result register; an
// allocation scans min(blocks_in_use, MAX_BLOCKS) entries and then writes back,
// as the control program reads one table entry per cycle through the registered
// read port. The next transaction is accepted the cycle after the result
// register is loaded, so none is taken while another is in progress.
// When the receiver stalls, the result is held, and a following item is
// processed up to its write-back step, where it waits for the register.
// Reset clears the free-space and label tables (per-slot valid bits), sets
// blocks_in_use to 8 and empties the result register. blocks_in_use sits at
// byte address 0 of the APB-style port and should be written only when idle.
`timescale 1ns / 1ps
`default_nettype none
module worst_fit_block_allocator
  import wfba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               operation_i,
  input  wire logic [2:0]         block_index_i,
  input  wire logic [7:0]         block_label_i,
  input  wire logic [15:0]        block_space_i,
  input  wire logic [15:0]        request_size_i,
  input  wire logic [7:0]         request_tag_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              status_o,
  output logic [7:0]              granted_label_o,
  output logic [2:0]              granted_index_o,
  output logic [15:0]             space_left_o,
  output logic [7:0]              echo_tag_o
);

  logic [3:0] biu_q, biu_d;
  logic       reg_sel;
  uact_e      act;
  dp_flags_t  flags;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_BLOCKS_IN_USE);

  always_comb begin
    biu_d = biu_q;
    if (psel && penable && pwrite && reg_sel) begin
      biu_d = pwdata[3:0];
    end
    prdata = reg_sel ? {28'd0, biu_q} : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q <= BLOCKS_IN_USE_RST;
    end else begin
      biu_q <= biu_d;
    end
  end

  assign in_stall_o = (act != ACT_CAPTURE);

  wfba_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .act_o   (act)
  );

  wfba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .act_i           (act),
    .blocks_in_use_i (biu_q),
    .in_valid_i      (in_valid_i),
    .operation_i     (operation_i),
    .block_index_i   (block_index_i),
    .block_label_i   (block_label_i),
    .block_space_i   (block_space_i),
    .request_size_i  (request_size_i),
    .request_tag_i   (request_tag_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .granted_label_o (granted_label_o),
    .granted_index_o (granted_index_o),
    .space_left_o    (space_left_o),
    .echo_tag_o      (echo_tag_o),
    .flags_o         (flags)
  );

endmodule
`default_nettype wire

// ===== test/wfba_checker.sv =====
// Checker for the worst-fit block allocator: shadow tables, expected results and comparison.
`timescale 1ns / 1ps
module wfba_checker
  import wfba_pkg::*;
#(
  parameter int unsigned SLOTS = MAX_BLOCKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               operation_i,
  input  logic [2:0]         block_index_i,
  input  logic [7:0]         block_label_i,
  input  logic [15:0]        block_space_i,
  input  logic [15:0]        request_size_i,
  input  logic [7:0]         request_tag_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [1:0]         status_o,
  input  logic [7:0]         granted_label_o,
  input  logic [2:0]         granted_index_o,
  input  logic [15:0]        space_left_o,
  input  logic [7:0]         echo_tag_o,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        grants_o,
  output int unsigned        no_fits_o
);

  typedef struct {
    status_e     status;
    logic [7:0]  label;
    logic [2:0]  slot;
    logic [15:0] space;
    logic [7:0]  tag;
  } grant_t;

  logic [15:0] space_tbl [SLOTS];
  logic [7:0]  label_tbl [SLOTS];
  logic [3:0]  scan_count;
  grant_t      grant_q [$];

  // Applies one transaction to the shadow tables and returns the result it should give.
  function automatic grant_t predict_grant(input logic op, input logic [2:0] slot,
                                           input logic [7:0] lbl, input logic [15:0] space,
                                           input logic [15:0] req, input logic [7:0] tag);
    grant_t      g;
    int unsigned n;
    int          best;
    int          j;
    g = '{status: ST_LOADED, label: 8'd0, slot: 3'd0, space: 16'd0, tag: tag};
    if (op == OP_LOAD) begin
      if (slot < SLOTS) begin
        space_tbl[slot] = space;
        label_tbl[slot] = lbl;
      end
      return g;
    end
    n = (scan_count > SLOTS) ? SLOTS : scan_count;
    best = -1;
    for (j = 0; j < n; j++) begin
      if (space_tbl[j] >= req && (best < 0 || space_tbl[j] > space_tbl[best])) begin
        best = j;
      end
    end
    if (best < 0) begin
      g.status = ST_NO_FIT;
      return g;
    end
    space_tbl[best] = space_tbl[best] - req;
    g.status = ST_ALLOCATED;
    g.label  = label_tbl[best];
    g.slot   = 3'(best);
    g.space  = space_tbl[best];
    return g;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t g;
    int     k;
    if (!rst_ni) begin
      for (k = 0; k < SLOTS; k++) begin
        space_tbl[k] = '0;
        label_tbl[k] = '0;
      end
      scan_count = BLOCKS_IN_USE_RST;
      grant_q.delete();
      fail_count_o = 0;
      grants_o     = 0;
      no_fits_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        // Register index sits above the byte offset; other indexes are ignored.
        if (paddr[PADDR_W-1:2] == REG_BLOCKS_IN_USE) begin
          scan_count = pwdata[3:0];
        end
      end
      if (in_valid_i && !in_stall_o) begin
        grant_q.push_back(predict_grant(operation_i, block_index_i, block_label_i,
                                        block_space_i, request_size_i, request_tag_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (grant_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with nothing expected, expected none, got status %0d tag %0h",
                   $time, status_o, echo_tag_o);
        end else begin
          g = grant_q.pop_front();
          check_field("status", 16'(g.status), 16'(status_o));
          check_field("granted_label", 16'(g.label), 16'(granted_label_o));
          check_field("granted_index", 16'(g.slot), 16'(granted_index_o));
          check_field("space_left", g.space, space_left_o);
          check_field("echo_tag", 16'(g.tag), 16'(echo_tag_o));
          if (g.status == ST_ALLOCATED) grants_o++;
          if (g.status == ST_NO_FIT) no_fits_o++;
        end
      end
    end
    pending_o = grant_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the worst-fit block allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import wfba_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned PHASES        = 11;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam logic        REG_SPARE     = 1'b1;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               operation_i;
  logic [2:0]         block_index_i;
  logic [7:0]         block_label_i;
  logic [15:0]        block_space_i;
  logic [15:0]        request_size_i;
  logic [7:0]         request_tag_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic [7:0]         granted_label_o;
  logic [2:0]         granted_index_o;
  logic [15:0]        space_left_o;
  logic [7:0]         echo_tag_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned grants;
  int unsigned no_fits;

  int unsigned cycles;
  int unsigned n_loads;
  int unsigned n_allocs;
  int unsigned burst_left;
  logic [15:0] loaded_space [8];

  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned stall_run;
  bit          stall_now;

  logic [3:0] scan_settings [PHASES] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd9,
                                         4'd8, 4'd2, 4'd7, 4'd4, 4'd6};

  worst_fit_block_allocator i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .operation_i, .block_index_i, .block_label_i,
    .block_space_i, .request_size_i, .request_tag_i, .out_valid_o, .out_stall_i,
    .status_o, .granted_label_o, .granted_index_o, .space_left_o, .echo_tag_o
  );

  wfba_checker i_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_o, .operation_i, .block_index_i, .block_label_i,
    .block_space_i, .request_size_i, .request_tag_i, .out_valid_o, .out_stall_i,
    .status_o, .granted_label_o, .granted_index_o, .space_left_o, .echo_tag_o,
    .fail_count_o(fail_count), .pending_o(pending), .grants_o(grants),
    .no_fits_o(no_fits)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver switches between no stalls, light stalls and heavy stalls.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(40, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: stall_now = 1'b0;
      1: stall_now = ($urandom_range(0, 1) == 1);
      default: stall_now = ($urandom_range(0, 3) != 0);
    endcase
    if (stall_now) stall_run++;
    else stall_run = 0;
    if (stall_run > 12) begin
      stall_now = 1'b0;
      stall_run = 0;
    end
    out_stall_i <= stall_now;
  end

  // All tasks below start and end at a falling edge.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic issue(input op_e op, input logic [2:0] slot, input logic [7:0] lbl,
                       input logic [15:0] space, input logic [15:0] req,
                       input logic [7:0] tag);
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    block_index_i  <= slot;
    block_label_i  <= lbl;
    block_space_i  <= space;
    request_size_i <= req;
    request_tag_i  <= tag;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (op == OP_LOAD) begin
      loaded_space[slot] = space;
      n_loads++;
    end else begin
      n_allocs++;
    end
  endtask

  // Holds the sender off until every outstanding transaction has been answered.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [15:0] pick_space();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(1, 255));
      4: return loaded_space[$urandom_range(0, 7)];
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_request();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return loaded_space[$urandom_range(0, 7)];
      3: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 4096));
    endcase
  endfunction

  task automatic random_item(input op_e op, input logic [2:0] slot);
    pace();
    issue(op, slot, 8'($urandom_range(0, 255)), pick_space(), pick_request(),
          8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned ph;
    int unsigned k;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid_i     <= 1'b0;
    operation_i    <= OP_LOAD;
    block_index_i  <= '0;
    block_label_i  <= '0;
    block_space_i  <= '0;
    request_size_i <= '0;
    request_tag_i  <= '0;
    for (k = 0; k < 8; k++) loaded_space[k] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: the cleared table, exact fits, ties and a zero request.
    issue(OP_ALLOC, 3'd0, 8'h00, 16'h0000, 16'h0000, 8'h01);
    issue(OP_ALLOC, 3'd7, 8'hFF, 16'hFFFF, 16'h0001, 8'h02);
    issue(OP_LOAD, 3'd0, 8'h00, 16'hFFFF, 16'hFFFF, 8'hFF);
    issue(OP_LOAD, 3'd7, 8'hFF, 16'hFFFF, 16'h0000, 8'h00);
    issue(OP_LOAD, 3'd3, 8'hA5, 16'd100, 16'h1234, 8'h5A);
    issue(OP_ALLOC, 3'd0, 8'h00, 16'h0000, 16'hFFFF, 8'hA5);
    issue(OP_ALLOC, 3'd0, 8'h00, 16'h0000, 16'hFFFF, 8'h3C);
    issue(OP_ALLOC, 3'd0, 8'h00, 16'h0000, 16'd100, 8'hC3);
    issue(OP_ALLOC, 3'd0, 8'h00, 16'h0000, 16'h0001, 8'h80);
    issue(OP_LOAD, 3'd5, 8'h5A, 16'h8000, 16'h0000, 8'h7F);
    issue(OP_LOAD, 3'd2, 8'h3C, 16'h8000, 16'h0000, 8'h10);
    issue(OP_ALLOC, 3'd0, 8'h00, 16'h0000, 16'h0000, 8'h20);
    issue(OP_ALLOC, 3'd0, 8'h00, 16'h0000, 16'h7FFF, 8'h40);
    issue(OP_ALLOC, 3'd0, 8'h00, 16'h0000, 16'h0001, 8'h04);
    issue(OP_LOAD, 3'd6, 8'h81, 16'h0001, 16'h0000, 8'h08);
    issue(OP_LOAD, 3'd1, 8'h7E, 16'h7FFF, 16'h0000, 8'hEF);
    issue(OP_ALLOC, 3'd0, 8'h00, 16'h0000, 16'h8000, 8'hF7);
    issue(OP_ALLOC, 3'd0, 8'h00, 16'h0000, 16'h0000, 8'hFE);

    // Random phases, each at its own scan count and starting from a refilled table.
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_BLOCKS_IN_USE, ($urandom() & ~32'hF) | 32'(scan_settings[ph]));
      if (ph == 2) write_reg(REG_SPARE, $urandom());
      for (k = 0; k < 8; k++) random_item(OP_LOAD, 3'(k));
      for (k = 8; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 3) == 0) random_item(OP_LOAD, 3'($urandom_range(0, 7)));
        else random_item(OP_ALLOC, 3'($urandom_range(0, 7)));
      end
    end
    drain();

    $display("Sent %0d loads and %0d allocation requests over %0d scan counts (0 to 15).",
             n_loads, n_allocs, PHASES);
    $display("Checked %0d grants and %0d no-fit answers; %0d mismatches.",
             grants, no_fits, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
